[rtl/modbus_rtu_response_parser_assert.svh]
// Assertion macros for the Modbus RTU response parser.
// Used by the top level; depends on nothing else.
`ifndef MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH

// same-cycle implication
`define MRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modbus rtu parser check failed");

// next-cycle implication
`define MRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modbus rtu parser check failed");

`endif

[rtl/mrp_pkg.sv]
// Shared types and constants of the Modbus RTU response parser.
// No dependencies.
`timescale 1ns / 1ps

package mrp_pkg;

   localparam logic [2:0] KIND_COIL     = 3'd0;
   localparam logic [2:0] KIND_REGISTER = 3'd1;
   localparam logic [2:0] KIND_SINGLE   = 3'd2;
   localparam logic [2:0] KIND_MULTI    = 3'd3;
   localparam logic [2:0] KIND_DIAG     = 3'd4;
   localparam logic [2:0] KIND_SUBFUNC  = 3'd5;
   localparam logic [2:0] KIND_EXCEPT   = 3'd6;
   localparam logic [2:0] KIND_VERDICT  = 3'd7;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_CRC      = 2'd2;
   localparam logic [1:0] STATUS_LONG     = 2'd3;

   localparam logic [1:0] CLASS_NORMAL = 2'd0;
   localparam logic [1:0] CLASS_FAULT  = 2'd1;
   localparam logic [1:0] CLASS_OTHER  = 2'd2;

   localparam logic [7:0] FC_READ_COILS      = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE   = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
   localparam logic [7:0] FC_READ_INPUT      = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
   localparam logic [7:0] FC_WRITE_REGISTER  = 8'h06;
   localparam logic [7:0] FC_READ_STATUS     = 8'h07;
   localparam logic [7:0] FC_EVENT_COUNTER   = 8'h0B;
   localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGISTERS = 8'h10;
   localparam logic [7:0] FC_EXCEPTION_BIT   = 8'h80;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] COIL_ON_VALUE = 16'hFF00;
   localparam logic [7:0]  STATUS_FAULT  = 8'hFF;
   localparam logic [7:0]  STATUS_NORMAL = 8'h00;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  slave_address;
      logic [7:0]  function_code;
      logic [7:0]  item_index;
      logic [15:0] value_word;
      logic [15:0] address_word;
      logic        coil_on;
      logic [1:0]  status_class;
      logic [7:0]  exception_code;
      logic [1:0]  frame_status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       field_valid;
      result_type field;
      logic       verdict_valid;
      result_type verdict;
   } bundle_type;

endpackage

[rtl/mrp_if.sv]
// Channel interfaces of the Modbus RTU response parser: frame bytes in, results out.
// No dependencies.
`timescale 1ns / 1ps

interface mrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface mrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  slave_address;
   logic [7:0]  function_code;
   logic [7:0]  item_index;
   logic [15:0] value_word;
   logic [15:0] address_word;
   logic        coil_on;
   logic [1:0]  status_class;
   logic [7:0]  exception_code;
   logic [1:0]  frame_status;
   logic        last;

   modport source (output valid, output kind, output slave_address, output function_code,
                   output item_index, output value_word, output address_word,
                   output coil_on, output status_class, output exception_code,
                   output frame_status, output last, input ready);
   modport sink (input valid, input kind, input slave_address, input function_code,
                 input item_index, input value_word, input address_word,
                 input coil_on, input status_class, input exception_code,
                 input frame_status, input last, output ready);
endinterface

[rtl/modbus_rtu_response_parser.sv]
// Channel   Dir  Word
// req_if    in   data_byte, frame_end (one frame byte)
// rsp_if    out  kind, addresses, values, verdict, last (one result)
//
// One byte is taken per cycle while the result side keeps up; the CRC update and field
// capture are one combinational pass from the frame state into the result register pair.
// A byte that yields a field and closes the frame gives two output words, field first.
// Reset is synchronous and returns the frame state to the start of a frame.
// A stalled output holds the pair; input is taken once its last word leaves.
`timescale 1ns / 1ps
`include "modbus_rtu_response_parser_assert.svh"

module modbus_rtu_response_parser #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic      clock,
   input  logic      reset,
   mrp_req_if.sink   req_if,
   mrp_rsp_if.source rsp_if
);

   mrp_pkg::bundle_type bundle;
   logic                load;
   logic                load_ok;

   mrp_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .load_ok (load_ok),
      .load    (load),
      .bundle  (bundle)
   );

   mrp_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .bundle  (bundle),
      .load_ok (load_ok),
      .rsp_if  (rsp_if)
   );

   `MRP_ASSERT_NOW(a_last_on_verdict, clock, reset, rsp_if.valid,
      (rsp_if.kind == mrp_pkg::KIND_VERDICT) == rsp_if.last)
   `MRP_ASSERT_NOW(a_end_gives_verdict, clock, reset,
      req_if.valid && req_if.ready && req_if.frame_end, bundle.verdict_valid)
   `MRP_ASSERT_NOW(a_field_not_verdict, clock, reset, load && bundle.field_valid,
      bundle.field.kind != mrp_pkg::KIND_VERDICT && !bundle.field.last)
   `MRP_ASSERT_NEXT(a_verdict_follows_field, clock, reset,
      load && bundle.field_valid && bundle.verdict_valid,
      rsp_if.valid && rsp_if.kind != mrp_pkg::KIND_VERDICT)

endmodule

[rtl/mrp_parser.sv]
// Frame state, running CRC and field assembly; one byte per accepted word.
// Depends on mrp_pkg and mrp_req_if.
`timescale 1ns / 1ps

module mrp_parser #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic               clock,
   input  logic               reset,
   mrp_req_if.sink            req_if,
   input  logic               load_ok,
   output logic               load,
   output mrp_pkg::bundle_type bundle
);

   localparam int PosW = $clog2(MAX_FRAME_BYTES + 2);
   localparam int CmpW = (PosW > 8) ? PosW : 8;
   localparam logic [PosW-1:0] MaxPos  = PosW'(MAX_FRAME_BYTES);
   localparam logic [PosW-1:0] LongPos = PosW'(MAX_FRAME_BYTES + 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      addr_ff, addr_in;
   logic [7:0]      func_ff, func_in;
   logic [7:0]      count_ff, count_in;
   logic [7:0]      high_ff, high_in;
   logic [15:0]     first_ff, first_in;
   logic [7:0]      vcount_ff, vcount_in;
   logic [7:0]      lag1_ff, lag1_in;
   logic [7:0]      lag2_ff, lag2_in;

   logic [CmpW-1:0] offset;
   logic [CmpW-1:0] coil_limit;
   logic [CmpW-1:0] reg_limit;
   logic [15:0]     word;
   logic [7:0]      b;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ mrp_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   assign req_if.ready = load_ok;
   assign load         = req_if.valid & load_ok;
   assign b            = req_if.data_byte;
   assign offset       = CmpW'(pos_ff) - CmpW'(4);
   assign coil_limit   = CmpW'(count_ff);
   assign reg_limit    = CmpW'({count_ff[7:1], 1'b0});
   assign word         = {high_ff, lag2_ff};

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      count_in  = count_ff;
      high_in   = high_ff;
      first_in  = first_ff;
      vcount_in = vcount_ff;
      lag1_in   = lag1_ff;
      lag2_in   = lag2_ff;
      bundle    = '0;
      bundle.field.slave_address = addr_ff;
      bundle.field.function_code = func_ff;

      if (load) begin
         if (pos_ff < MaxPos) begin
            crc_in = crc_feed(crc_ff, b);
            if (pos_ff == PosW'(0)) addr_in = b;
            if (pos_ff == PosW'(1)) func_in = b;
            if (pos_ff >= PosW'(4)) begin
               if (func_ff >= mrp_pkg::FC_EXCEPTION_BIT) begin
                  if (offset == '0) begin
                     bundle.field_valid          = 1'b1;
                     bundle.field.kind           = mrp_pkg::KIND_EXCEPT;
                     bundle.field.exception_code = lag2_ff;
                  end
               end else begin
                  case (func_ff)
                     mrp_pkg::FC_READ_COILS, mrp_pkg::FC_READ_DISCRETE: begin
                        if (offset == '0) begin
                           count_in  = lag2_ff;
                           vcount_in = '0;
                        end else if (offset <= coil_limit) begin
                           bundle.field_valid      = 1'b1;
                           bundle.field.kind       = mrp_pkg::KIND_COIL;
                           bundle.field.item_index = vcount_ff;
                           bundle.field.value_word = {8'h00, lag2_ff};
                           vcount_in               = vcount_ff + 8'd1;
                        end
                     end
                     mrp_pkg::FC_READ_HOLDING, mrp_pkg::FC_READ_INPUT: begin
                        if (offset == '0) begin
                           count_in  = lag2_ff;
                           vcount_in = '0;
                        end else if (offset <= reg_limit) begin
                           if (offset[0]) begin
                              high_in = lag2_ff;
                           end else begin
                              bundle.field_valid      = 1'b1;
                              bundle.field.kind       = mrp_pkg::KIND_REGISTER;
                              bundle.field.item_index = vcount_ff;
                              bundle.field.value_word = word;
                              vcount_in               = vcount_ff + 8'd1;
                           end
                        end
                     end
                     mrp_pkg::FC_WRITE_COIL, mrp_pkg::FC_WRITE_REGISTER,
                     mrp_pkg::FC_WRITE_COILS, mrp_pkg::FC_WRITE_REGISTERS: begin
                        if (offset == CmpW'(0) || offset == CmpW'(2)) begin
                           high_in = lag2_ff;
                        end else if (offset == CmpW'(1)) begin
                           first_in = word;
                        end else if (offset == CmpW'(3)) begin
                           bundle.field_valid        = 1'b1;
                           bundle.field.kind         =
                              (func_ff == mrp_pkg::FC_WRITE_COIL ||
                               func_ff == mrp_pkg::FC_WRITE_REGISTER) ?
                              mrp_pkg::KIND_SINGLE : mrp_pkg::KIND_MULTI;
                           bundle.field.value_word   = word;
                           bundle.field.address_word = first_ff;
                           bundle.field.coil_on      = (func_ff == mrp_pkg::FC_WRITE_COIL) &&
                                                       (word == mrp_pkg::COIL_ON_VALUE);
                        end
                     end
                     mrp_pkg::FC_READ_STATUS: begin
                        if (offset == '0) begin
                           bundle.field_valid      = 1'b1;
                           bundle.field.kind       = mrp_pkg::KIND_DIAG;
                           bundle.field.value_word = {8'h00, lag2_ff};
                           if (lag2_ff == mrp_pkg::STATUS_NORMAL) begin
                              bundle.field.status_class = mrp_pkg::CLASS_NORMAL;
                           end else if (lag2_ff == mrp_pkg::STATUS_FAULT) begin
                              bundle.field.status_class = mrp_pkg::CLASS_FAULT;
                           end else begin
                              bundle.field.status_class = mrp_pkg::CLASS_OTHER;
                           end
                        end
                     end
                     mrp_pkg::FC_EVENT_COUNTER: begin
                        if (offset == '0) begin
                           high_in = lag2_ff;
                        end else if (offset == CmpW'(1)) begin
                           bundle.field_valid      = 1'b1;
                           bundle.field.kind       = mrp_pkg::KIND_SUBFUNC;
                           bundle.field.value_word = word;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            lag2_in = lag1_ff;
            lag1_in = b;
            pos_in  = pos_ff + PosW'(1);
         end else begin
            pos_in = LongPos;
         end

         if (req_if.frame_end) begin
            bundle.verdict_valid         = 1'b1;
            bundle.verdict.kind          = mrp_pkg::KIND_VERDICT;
            bundle.verdict.slave_address = addr_in;
            bundle.verdict.function_code = func_in;
            bundle.verdict.last          = 1'b1;
            if (pos_in < PosW'(4)) begin
               bundle.verdict.frame_status = mrp_pkg::STATUS_SHORT;
            end else if (pos_in > MaxPos) begin
               bundle.verdict.frame_status = mrp_pkg::STATUS_LONG;
            end else if (crc_in != 16'h0000) begin
               bundle.verdict.frame_status = mrp_pkg::STATUS_CRC;
            end else begin
               bundle.verdict.frame_status = mrp_pkg::STATUS_OK;
            end
            pos_in    = '0;
            crc_in    = mrp_pkg::CRC_INIT;
            addr_in   = '0;
            func_in   = '0;
            count_in  = '0;
            high_in   = '0;
            first_in  = '0;
            vcount_in = '0;
            lag1_in   = '0;
            lag2_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= mrp_pkg::CRC_INIT;
         addr_ff   <= '0;
         func_ff   <= '0;
         count_ff  <= '0;
         high_ff   <= '0;
         first_ff  <= '0;
         vcount_ff <= '0;
         lag1_ff   <= '0;
         lag2_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         addr_ff   <= addr_in;
         func_ff   <= func_in;
         count_ff  <= count_in;
         high_ff   <= high_in;
         first_ff  <= first_in;
         vcount_ff <= vcount_in;
         lag1_ff   <= lag1_in;
         lag2_ff   <= lag2_in;
      end
   end

endmodule

[rtl/mrp_out.sv]
// Result register pair: holds a field word and a verdict word, sends field first.
// Depends on mrp_pkg and mrp_rsp_if.
`timescale 1ns / 1ps

module mrp_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mrp_pkg::bundle_type bundle,
   output logic                load_ok,
   mrp_rsp_if.source           rsp_if
);

   logic                fv_ff, fv_in;
   logic                vv_ff, vv_in;
   mrp_pkg::result_type f_ff, f_in;
   mrp_pkg::result_type v_ff, v_in;
   mrp_pkg::result_type cur;
   logic                pop;

   assign cur     = fv_ff ? f_ff : v_ff;
   assign pop     = (fv_ff | vv_ff) & rsp_if.ready;
   assign load_ok = !(fv_ff | vv_ff) || (pop && !(fv_ff && vv_ff));

   assign rsp_if.valid          = fv_ff | vv_ff;
   assign rsp_if.kind           = cur.kind;
   assign rsp_if.slave_address  = cur.slave_address;
   assign rsp_if.function_code  = cur.function_code;
   assign rsp_if.item_index     = cur.item_index;
   assign rsp_if.value_word     = cur.value_word;
   assign rsp_if.address_word   = cur.address_word;
   assign rsp_if.coil_on        = cur.coil_on;
   assign rsp_if.status_class   = cur.status_class;
   assign rsp_if.exception_code = cur.exception_code;
   assign rsp_if.frame_status   = cur.frame_status;
   assign rsp_if.last           = cur.last;

   always_comb begin
      fv_in = fv_ff;
      vv_in = vv_ff;
      f_in  = f_ff;
      v_in  = v_ff;
      if (pop) begin
         if (fv_ff) begin
            fv_in = 1'b0;
         end else begin
            vv_in = 1'b0;
         end
      end
      if (load) begin
         fv_in = bundle.field_valid;
         vv_in = bundle.verdict_valid;
         f_in  = bundle.field;
         v_in  = bundle.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
         vv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
         vv_ff <= vv_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff <= f_in;
      v_ff <= v_in;
   end

endmodule

[verif/mrp_parse_checker.sv]
// Result checker for the Modbus RTU response parser: watches both channels,
// predicts the results of every accepted frame byte and compares them in order.
// Depends on mrp_pkg and the channel interfaces in mrp_if.sv.
`timescale 1ns / 1ps

module mrp_parse_checker #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic clock,
   input  logic reset,
   mrp_req_if   req_mon,
   mrp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   expect_count
);
   import mrp_pkg::*;

   logic [8:0]  frame_pos;
   logic [15:0] frame_crc;
   logic [7:0]  frame_addr;
   logic [7:0]  frame_func;
   logic [7:0]  byte_count;
   logic [7:0]  high_byte;
   logic [15:0] first_word;
   logic [7:0]  item_count;
   logic [7:0]  lag_one;
   logic [7:0]  lag_two;

   result_type expected_results[$];

   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic result_type blank_result(logic [2:0] kind);
      result_type r;
      r = '0;
      r.kind = kind;
      r.slave_address = frame_addr;
      r.function_code = frame_func;
      return r;
   endfunction

   function automatic string show(result_type r);
      return $sformatf({"kind=%0d addr=%02h fc=%02h idx=%0d val=%04h adr=%04h on=%0b ",
                        "class=%0d exc=%02h status=%0d last=%0b"},
                       r.kind, r.slave_address, r.function_code, r.item_index,
                       r.value_word, r.address_word, r.coil_on, r.status_class,
                       r.exception_code, r.frame_status, r.last);
   endfunction

   task automatic clear_frame();
      frame_pos = '0;
      frame_crc = CRC_INIT;
      frame_addr = '0;
      frame_func = '0;
      byte_count = '0;
      high_byte = '0;
      first_word = '0;
      item_count = '0;
      lag_one = '0;
      lag_two = '0;
   endtask

   // decode one confirmed data byte at data offset d
   task automatic decode_data(input logic [7:0] b, input logic [7:0] d);
      result_type r;
      logic [15:0] word;
      word = {high_byte, b};
      if (frame_func >= FC_EXCEPTION_BIT) begin
         if (d == 0) begin
            r = blank_result(KIND_EXCEPT);
            r.exception_code = b;
            expected_results.push_back(r);
         end
      end else begin
         case (frame_func)
            FC_READ_COILS, FC_READ_DISCRETE: begin
               if (d == 0) begin
                  byte_count = b;
                  item_count = '0;
               end else if (d <= byte_count) begin
                  r = blank_result(KIND_COIL);
                  r.item_index = item_count;
                  r.value_word = {8'h00, b};
                  expected_results.push_back(r);
                  item_count++;
               end
            end
            FC_READ_HOLDING, FC_READ_INPUT: begin
               if (d == 0) begin
                  byte_count = b;
                  item_count = '0;
               end else if (d <= {byte_count[7:1], 1'b0}) begin
                  if (d[0]) begin
                     high_byte = b;
                  end else begin
                     r = blank_result(KIND_REGISTER);
                     r.item_index = item_count;
                     r.value_word = word;
                     expected_results.push_back(r);
                     item_count++;
                  end
               end
            end
            FC_WRITE_COIL, FC_WRITE_REGISTER, FC_WRITE_COILS, FC_WRITE_REGISTERS: begin
               if (d == 0 || d == 2) begin
                  high_byte = b;
               end else if (d == 1) begin
                  first_word = word;
               end else if (d == 3) begin
                  r = blank_result((frame_func == FC_WRITE_COIL ||
                                    frame_func == FC_WRITE_REGISTER) ? KIND_SINGLE : KIND_MULTI);
                  r.value_word = word;
                  r.address_word = first_word;
                  r.coil_on = (frame_func == FC_WRITE_COIL) && (word == COIL_ON_VALUE);
                  expected_results.push_back(r);
               end
            end
            FC_READ_STATUS: begin
               if (d == 0) begin
                  r = blank_result(KIND_DIAG);
                  r.value_word = {8'h00, b};
                  r.status_class = (b == STATUS_NORMAL) ? CLASS_NORMAL :
                                   (b == STATUS_FAULT) ? CLASS_FAULT : CLASS_OTHER;
                  expected_results.push_back(r);
               end
            end
            FC_EVENT_COUNTER: begin
               if (d == 0) begin
                  high_byte = b;
               end else if (d == 1) begin
                  r = blank_result(KIND_SUBFUNC);
                  r.value_word = word;
                  expected_results.push_back(r);
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic eof);
      result_type r;
      if (frame_pos < MAX_FRAME_BYTES) begin
         frame_crc = crc_update(frame_crc, b);
         if (frame_pos == 0) frame_addr = b;
         if (frame_pos == 1) frame_func = b;
         if (frame_pos >= 4) decode_data(lag_two, 8'(frame_pos - 9'd4));
         lag_two = lag_one;
         lag_one = b;
         frame_pos++;
      end else begin
         frame_pos = 9'(MAX_FRAME_BYTES + 1);
      end
      if (eof) begin
         r = blank_result(KIND_VERDICT);
         if (frame_pos < 4)
            r.frame_status = STATUS_SHORT;
         else if (frame_pos > MAX_FRAME_BYTES)
            r.frame_status = STATUS_LONG;
         else if (frame_crc != 16'h0000)
            r.frame_status = STATUS_CRC;
         else
            r.frame_status = STATUS_OK;
         r.last = 1'b1;
         expected_results.push_back(r);
         clear_frame();
      end
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got = '0;
      got.kind = rsp_mon.kind;
      got.slave_address = rsp_mon.slave_address;
      got.function_code = rsp_mon.function_code;
      got.item_index = rsp_mon.item_index;
      got.value_word = rsp_mon.value_word;
      got.address_word = rsp_mon.address_word;
      got.coil_on = rsp_mon.coil_on;
      got.status_class = rsp_mon.status_class;
      got.exception_code = rsp_mon.exception_code;
      got.frame_status = rsp_mon.frame_status;
      got.last = rsp_mon.last;
      if (expected_results.size() == 0) begin
         if (fail_count < 10)
            $display("%0t: unexpected result: %s", $realtime, show(got));
         fail_count++;
      end else begin
         want = expected_results.pop_front();
         if (got !== want) begin
            if (fail_count < 10)
               $display("%0t: mismatch\n   expected %s\n   actual   %s",
                        $realtime, show(want), show(got));
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.data_byte, req_mon.frame_end);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      expect_count = expected_results.size();
   end

endmodule

[verif/tb_top.sv]
// Testbench top for the Modbus RTU response parser: drives frame bytes, paces the
// result channel and gives the verdict. Depends on mrp_pkg, mrp_if.sv, the parser
// and mrp_parse_checker.
`timescale 1ns / 1ps

module tb_top;
   import mrp_pkg::*;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int TARGET_BYTES = 1650;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_hold = 1'b0;
   int   bytes_sent = 0;
   int   fail_count;
   int   expect_count;

   logic [7:0] frame_buf[$];
   logic [7:0] known_fc[10] = '{FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING,
                               FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REGISTER,
                               FC_READ_STATUS, FC_EVENT_COUNTER, FC_WRITE_COILS,
                               FC_WRITE_REGISTERS};

   mrp_req_if req_if();
   mrp_rsp_if rsp_if();

   modbus_rtu_response_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   mrp_parse_checker #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) parse_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .fail_count   (fail_count),
      .expect_count (expect_count)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] frame_crc(input int upto);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < upto; i++) begin
         c = c ^ {8'h00, frame_buf[i]};
         for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic append_crc();
      logic [15:0] c;
      c = frame_crc(frame_buf.size());
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic add_payload(input logic [7:0] fc);
      int n;
      if (fc >= FC_EXCEPTION_BIT) begin
         frame_buf.push_back(8'($urandom));
         return;
      end
      case (fc)
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
            n = $urandom_range(0, 12);
            frame_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(n));
            repeat (n) frame_buf.push_back(8'($urandom));
         end
         FC_WRITE_COIL, FC_WRITE_REGISTER, FC_WRITE_COILS, FC_WRITE_REGISTERS: begin
            frame_buf.push_back(8'($urandom));
            frame_buf.push_back(8'($urandom));
            if (fc == FC_WRITE_COIL && $urandom_range(0, 1) == 1) begin
               frame_buf.push_back(COIL_ON_VALUE[15:8]);
               frame_buf.push_back(COIL_ON_VALUE[7:0]);
            end else begin
               frame_buf.push_back(8'($urandom));
               frame_buf.push_back(8'($urandom));
            end
         end
         FC_READ_STATUS: begin
            n = $urandom_range(0, 2);
            frame_buf.push_back((n == 0) ? STATUS_NORMAL :
                                (n == 1) ? STATUS_FAULT : 8'($urandom));
         end
         FC_EVENT_COUNTER: begin
            repeat (($urandom_range(0, 3) == 0) ? 4 : 2) frame_buf.push_back(8'($urandom));
         end
         default: begin
            repeat ($urandom_range(0, 8)) frame_buf.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic make_frame();
      int pick;
      int n;
      logic [7:0] fc;
      frame_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 88) begin
         // too short, or plain noise
         n = (pick >= 94) ? $urandom_range(4, 12) : $urandom_range(1, 3);
         repeat (n) frame_buf.push_back(8'($urandom));
         return;
      end
      if (pick >= 80)
         fc = 8'($urandom_range(17, 127));
      else if ($urandom_range(0, 9) == 0)
         fc = FC_EXCEPTION_BIT | 8'($urandom_range(0, 127));
      else
         fc = known_fc[$urandom_range(0, 9)];
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(fc);
      add_payload(fc);
      append_crc();
      if (pick >= 60 && pick < 70) begin
         n = $urandom_range(0, frame_buf.size() - 1);
         frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
      end else if (pick >= 70 && pick < 80) begin
         repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
      end
   endtask

   task automatic make_long_frame(input int len, input logic [7:0] fc);
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(fc);
      frame_buf.push_back(8'(len - 5));
      while (frame_buf.size() < len - 2) frame_buf.push_back(8'($urandom));
      append_crc();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eof, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.frame_end <= eof;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      bit no_gaps;
      no_gaps = ($urandom_range(0, 3) == 0);
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1, no_gaps);
   endtask

   // hold until every expected result has come
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (expect_count == 0);
      @(posedge clock);
   endtask

   initial begin
      int frame_no;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.frame_end = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      frame_buf = '{8'hFF, FC_WRITE_COIL, 8'hFF, 8'hFF, COIL_ON_VALUE[15:8], COIL_ON_VALUE[7:0]};
      append_crc();
      send_frame();
      frame_buf = '{8'h00, FC_EXCEPTION_BIT | FC_READ_HOLDING, 8'hFF};
      append_crc();
      send_frame();
      frame_buf = '{8'h55};
      send_frame();
      frame_buf = '{8'hAA, FC_READ_COILS, 8'h02};
      send_frame();
      frame_buf = '{8'h01, FC_READ_HOLDING, 8'h00, 8'h00};
      send_frame();
      drain_results();

      frame_no = 0;
      while (bytes_sent < TARGET_BYTES) begin
         if (frame_no == 15)
            make_long_frame(MAX_FRAME_BYTES, FC_READ_HOLDING);
         else if (frame_no == 45)
            make_long_frame($urandom_range(MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 44),
                            FC_READ_COILS);
         else
            make_frame();
         send_frame();
         frame_no++;
         if (frame_no % 40 == 0) drain_results();
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (expect_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expect_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      int stall;
      bit quiet;
      rsp_if.ready = 1'b0;
      quiet = 1'b0;
      forever begin
         if ($urandom_range(0, 23) == 0) quiet = !quiet;
         stall = quiet ? 0 : $urandom_range(0, 13);
         if (stall > 0 || rsp_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // long stall on the result side while bytes keep coming
   initial begin
      wait (bytes_sent >= 300);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

endmodule
